// ===== hdl/yrd_pkg.sv =====
package yrd_pkg;

   localparam int STREAM_SLOTS = 8;
   localparam int SLOT_W = 3;
   localparam int HDR_LEN = 12;

   localparam logic [1:0] REQ_BYTE = 2'd0;
   localparam logic [1:0] REQ_OPEN = 2'd1;
   localparam logic [1:0] REQ_CREDIT = 2'd2;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   localparam logic [1:0] T_DATA = 2'd0;
   localparam logic [1:0] T_WINDOW = 2'd1;
   localparam logic [1:0] T_PING = 2'd2;
   localparam logic [1:0] T_GOAWAY = 2'd3;

   localparam logic [3:0] F_SYN = 4'd1;
   localparam logic [3:0] F_ACK = 4'd2;
   localparam logic [3:0] F_FIN = 4'd4;
   localparam logic [3:0] F_RST = 4'd8;

   localparam int M_ACKED = 0;
   localparam int M_RFIN = 1;
   localparam int M_RESET = 2;

   localparam logic [2:0] K_NONE = 3'd0;
   localparam logic [2:0] K_PAYLOAD = 3'd1;
   localparam logic [2:0] K_CTRL = 3'd2;
   localparam logic [2:0] K_OPENED = 3'd3;
   localparam logic [2:0] K_ERROR = 3'd4;

   localparam logic [2:0] E_NONE = 3'd0;
   localparam logic [2:0] E_PROTO = 3'd1;
   localparam logic [2:0] E_CLOSED = 3'd2;
   localparam logic [2:0] E_CAP = 3'd3;
   localparam logic [2:0] E_STATE = 3'd4;

   localparam logic REG_INITIAL_WINDOW = 1'b0;
   localparam logic REG_DISCARD_LIMIT = 1'b1;

   localparam logic [31:0] RESET_WINDOW = 32'd262144;
   localparam logic [31:0] RESET_DISCARD = 32'd262144;

   typedef struct packed {
      logic load;
      logic look;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== hdl/yrd_ctrl.sv =====
module yrd_ctrl
   import yrd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic accept;

   assign req_stall = !((state_ff == S_IDLE) || ((state_ff == S_EXEC) && status.out_free));
   assign accept = req_valid && !req_stall;

   assign cmd.load = accept;
   assign cmd.look = (state_ff == S_LOOK);
   assign cmd.exec = (state_ff == S_EXEC) && status.out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_LOOK;
         end
         S_LOOK: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (status.out_free) state_in = accept ? S_LOOK : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/yrd_datapath.sv =====
module yrd_datapath
   import yrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_data_byte,
   input  logic [2:0]  req_credit_slot,
   input  logic [31:0] req_credit_amount,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_out_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [2:0]  rsp_stream_slot,
   output logic [31:0] rsp_stream_id,
   output logic [1:0]  rsp_ctrl_type,
   output logic [3:0]  rsp_ctrl_flags,
   output logic [31:0] rsp_ctrl_value,
   output logic [2:0]  rsp_error_code,
   input  logic        cfg_write,
   input  logic        cfg_sel,
   input  logic [31:0] cfg_wdata,
   output logic [31:0] cfg_rdata
);

   logic [31:0] iw_ff, dl_ff;
   logic [1:0] typ_ff;
   logic [7:0] byte_ff;
   logic [SLOT_W-1:0] cslot_ff;
   logic [31:0] camt_ff;

   logic [7:0] hdr_ff [HDR_LEN];
   logic [3:0] hcnt_ff, hcnt_in;
   logic fa_ff, fa_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] fstream_ff, fstream_in;
   logic [3:0] fflags_ff, fflags_in;
   logic drop_ff, drop_in;
   logic [31:0] dt_ff, dt_in;
   logic [31:0] nlid_ff, nlid_in;
   logic [31:0] phid_ff, phid_in;
   logic gone_ff, gone_in;
   logic [2:0] sticky_ff, sticky_in;

   logic [31:0] ids_ff [STREAM_SLOTS];
   logic [2:0] marks_ff [STREAM_SLOTS];
   logic [31:0] rc_ff [STREAM_SLOTS];
   logic [31:0] sc_ff [STREAM_SLOTS];

   logic hit_ff, free_ok_ff;
   logic [SLOT_W-1:0] hidx_ff, fidx_ff;
   logic hit_c, free_c;
   logic [SLOT_W-1:0] hidx_c, fidx_c;
   logic [31:0] look_id;

   logic ov_ff;
   logic [2:0] kind_ff, kind_in;
   logic [7:0] pb_ff, pb_in;
   logic [2:0] slot_ff, slot_in;
   logic [31:0] sid_ff, sid_in;
   logic [1:0] ct_ff, ct_in;
   logic [3:0] cf_ff, cf_in;
   logic [31:0] cv_ff, cv_in;
   logic [2:0] ec_ff, ec_in;

   logic hdr_we;
   logic [3:0] hc;
   logic [SLOT_W-1:0] widx;
   logic we_ids, we_marks, we_rc, we_sc;
   logic [31:0] w_ids, w_rc, w_sc;
   logic [2:0] w_marks;

   logic [7:0] h_type;
   logic [15:0] h_flags;
   logic [3:0] f;
   logic [31:0] h_id, h_value;
   logic [2:0] mk, mk_new;
   logic [31:0] rc, sc, droom;
   logic live, discard, bad;
   logic [31:0] left_dec;

   assign status.out_free = !ov_ff || !rsp_stall;
   assign cfg_rdata = (cfg_sel == REG_INITIAL_WINDOW) ? iw_ff : dl_ff;

   assign look_id = fa_ff ? fstream_ff : {hdr_ff[4], hdr_ff[5], hdr_ff[6], hdr_ff[7]};

   always_comb begin
      hit_c = 1'b0;
      hidx_c = '0;
      free_c = 1'b0;
      fidx_c = '0;
      for (int i = STREAM_SLOTS - 1; i >= 0; i--) begin
         if (look_id != 32'd0 && ids_ff[i] == look_id) begin
            hit_c = 1'b1;
            hidx_c = SLOT_W'(i);
         end
         if (ids_ff[i] == 32'd0) begin
            free_c = 1'b1;
            fidx_c = SLOT_W'(i);
         end
      end
   end

   assign hc = (hcnt_ff >= 4'(HDR_LEN)) ? 4'd0 : hcnt_ff;
   assign h_type = hdr_ff[1];
   assign h_flags = {hdr_ff[2], hdr_ff[3]};
   assign f = h_flags[3:0];
   assign h_id = {hdr_ff[4], hdr_ff[5], hdr_ff[6], hdr_ff[7]};
   assign h_value = {hdr_ff[8], hdr_ff[9], hdr_ff[10], byte_ff};
   assign mk = marks_ff[hidx_ff];
   assign rc = rc_ff[hidx_ff];
   assign sc = sc_ff[hidx_ff];
   assign droom = (dt_ff > dl_ff) ? 32'd0 : dl_ff - dt_ff;
   assign left_dec = left_ff - 32'd1;

   always_comb begin
      hcnt_in = hcnt_ff;
      fa_in = fa_ff;
      left_in = left_ff;
      fstream_in = fstream_ff;
      fflags_in = fflags_ff;
      drop_in = drop_ff;
      dt_in = dt_ff;
      nlid_in = nlid_ff;
      phid_in = phid_ff;
      gone_in = gone_ff;
      sticky_in = sticky_ff;
      hdr_we = 1'b0;
      widx = hidx_ff;
      we_ids = 1'b0;
      we_marks = 1'b0;
      we_rc = 1'b0;
      we_sc = 1'b0;
      w_ids = nlid_ff;
      w_marks = mk;
      w_rc = rc;
      w_sc = sc;
      kind_in = K_NONE;
      pb_in = '0;
      slot_in = '0;
      sid_in = '0;
      ct_in = '0;
      cf_in = '0;
      cv_in = '0;
      ec_in = E_NONE;
      live = hit_ff && !mk[M_RESET];
      mk_new = mk;
      discard = 1'b0;
      bad = 1'b0;

      if (typ_ff == REQ_UNKNOWN) begin
         kind_in = K_NONE;
      end else if (sticky_ff != E_NONE) begin
         kind_in = K_ERROR;
         ec_in = sticky_ff;
      end else if (typ_ff == REQ_BYTE) begin
         if (!fa_ff) begin
            hdr_we = 1'b1;
            hcnt_in = hc + 4'd1;
            if (hc == 4'(HDR_LEN - 1)) begin
               if (hdr_ff[0] != 8'd0 || h_type > 8'd3 || h_flags[15:4] != 12'd0) begin
                  bad = 1'b1;
               end else if (h_type[1:0] == T_PING) begin
                  if (h_id != 32'd0 || f != F_SYN) begin
                     bad = 1'b1;
                  end else begin
                     hcnt_in = 4'd0;
                     kind_in = K_CTRL;
                     ct_in = T_PING;
                     cf_in = F_ACK;
                     cv_in = h_value;
                  end
               end else if (h_type[1:0] == T_GOAWAY) begin
                  if (h_id != 32'd0 || f != 4'd0 || h_value > 32'd2) begin
                     bad = 1'b1;
                  end else if (h_value != 32'd0) begin
                     kind_in = K_ERROR;
                     ec_in = E_CLOSED;
                     sticky_in = E_CLOSED;
                  end else begin
                     gone_in = 1'b1;
                     hcnt_in = 4'd0;
                  end
               end else begin
                  if (h_id == 32'd0 || (f & (F_SYN | F_ACK)) == (F_SYN | F_ACK) ||
                      (f & (F_FIN | F_RST)) == (F_FIN | F_RST)) begin
                     bad = 1'b1;
                  end
                  if ((f & F_SYN) != 4'd0) begin
                     if (h_id[0] || h_id <= phid_ff || (f & F_RST) != 4'd0) bad = 1'b1;
                  end else if (h_id[0] ? (nlid_ff != 32'd0 && h_id >= nlid_ff)
                                       : (h_id > phid_ff)) begin
                     bad = 1'b1;
                  end
                  if (live) begin
                     if ((f & F_ACK) != 4'd0 && mk[M_ACKED]) bad = 1'b1;
                     if (!mk[M_ACKED] && (f & (F_ACK | F_RST)) == 4'd0) bad = 1'b1;
                     if (mk[M_RFIN] && (f & F_RST) == 4'd0 &&
                         (h_type[1:0] == T_DATA || (f & F_FIN) != 4'd0)) bad = 1'b1;
                     if (h_type[1:0] == T_DATA && h_value > rc) bad = 1'b1;
                     if (h_type[1:0] == T_WINDOW && h_value > ~sc) bad = 1'b1;
                     if ((f & F_ACK) != 4'd0) mk_new[M_ACKED] = 1'b1;
                     if ((f & F_RST) != 4'd0) mk_new[M_RESET] = 1'b1;
                  end
                  discard = !hit_ff || mk_new[M_RESET];
                  if (h_type[1:0] == T_DATA && discard &&
                      (h_value > iw_ff || h_value > droom)) bad = 1'b1;
                  if (!bad) begin
                     if (live) begin
                        we_marks = 1'b1;
                        we_rc = (h_type[1:0] == T_DATA);
                        we_sc = (h_type[1:0] != T_DATA);
                        w_rc = rc - h_value;
                        w_sc = sc + h_value;
                     end
                     if ((f & F_SYN) != 4'd0) phid_in = h_id;
                     fstream_in = h_id;
                     fflags_in = f;
                     drop_in = discard;
                     left_in = (h_type[1:0] == T_DATA) ? h_value : 32'd0;
                     fa_in = 1'b1;
                     hcnt_in = 4'd0;
                     if (h_type[1:0] != T_DATA || h_value == 32'd0) begin
                        if (hit_ff && !mk_new[M_RESET] && (f & F_FIN) != 4'd0) begin
                           mk_new[M_RFIN] = 1'b1;
                           we_marks = 1'b1;
                        end
                        fa_in = 1'b0;
                     end
                     w_marks = mk_new;
                     if ((f & F_SYN) != 4'd0) begin
                        kind_in = K_CTRL;
                        sid_in = h_id;
                        ct_in = T_WINDOW;
                        cf_in = F_RST;
                     end
                  end
               end
               if (bad) begin
                  we_marks = 1'b0;
                  we_rc = 1'b0;
                  we_sc = 1'b0;
                  kind_in = K_ERROR;
                  ec_in = E_PROTO;
                  sticky_in = E_PROTO;
               end
            end
         end else begin
            if (drop_ff && droom == 32'd0) begin
               bad = 1'b1;
               kind_in = K_ERROR;
               ec_in = E_PROTO;
               sticky_in = E_PROTO;
            end else if (!drop_ff && !hit_ff) begin
               bad = 1'b1;
               kind_in = K_ERROR;
               ec_in = E_STATE;
               sticky_in = E_STATE;
            end else begin
               if (drop_ff) begin
                  dt_in = dt_ff + 32'd1;
               end else begin
                  kind_in = K_PAYLOAD;
                  pb_in = byte_ff;
                  slot_in = 3'(hidx_ff);
                  sid_in = fstream_ff;
               end
               left_in = left_dec;
               if (left_dec == 32'd0) begin
                  if (hit_ff && !mk[M_RESET] && (fflags_ff & F_FIN) != 4'd0) begin
                     mk_new[M_RFIN] = 1'b1;
                     we_marks = 1'b1;
                     w_marks = mk_new;
                  end
                  fa_in = 1'b0;
                  hcnt_in = 4'd0;
               end
            end
         end
      end else if (typ_ff == REQ_OPEN) begin
         widx = fidx_ff;
         if (gone_ff) begin
            kind_in = K_ERROR;
            ec_in = E_CLOSED;
         end else if (nlid_ff == 32'd0 || !free_ok_ff) begin
            kind_in = K_ERROR;
            ec_in = E_CAP;
         end else begin
            we_ids = 1'b1;
            we_marks = 1'b1;
            we_rc = 1'b1;
            we_sc = 1'b1;
            w_ids = nlid_ff;
            w_marks = 3'd0;
            w_rc = iw_ff;
            w_sc = iw_ff;
            nlid_in = (nlid_ff == 32'hFFFF_FFFF) ? 32'd0 : nlid_ff + 32'd2;
            kind_in = K_OPENED;
            slot_in = 3'(fidx_ff);
            sid_in = nlid_ff;
            ct_in = T_WINDOW;
            cf_in = F_SYN;
         end
      end else begin
         widx = cslot_ff;
         if (ids_ff[cslot_ff] == 32'd0 || marks_ff[cslot_ff][M_RESET] ||
             marks_ff[cslot_ff][M_RFIN] || camt_ff == 32'd0) begin
            kind_in = K_NONE;
         end else if (rc_ff[cslot_ff] > iw_ff || camt_ff > iw_ff - rc_ff[cslot_ff]) begin
            kind_in = K_ERROR;
            ec_in = E_PROTO;
            sticky_in = E_PROTO;
         end else begin
            we_rc = 1'b1;
            w_rc = rc_ff[cslot_ff] + camt_ff;
            kind_in = K_CTRL;
            sid_in = ids_ff[cslot_ff];
            ct_in = T_WINDOW;
            cv_in = camt_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         typ_ff <= req_type;
         byte_ff <= req_data_byte;
         cslot_ff <= req_credit_slot;
         camt_ff <= req_credit_amount;
      end
      if (cmd.look) begin
         hit_ff <= hit_c;
         hidx_ff <= hidx_c;
         free_ok_ff <= free_c;
         fidx_ff <= fidx_c;
      end
      if (cmd.exec) begin
         if (hdr_we) hdr_ff[hc] <= byte_ff;
         if (we_rc) rc_ff[widx] <= w_rc;
         if (we_sc) sc_ff[widx] <= w_sc;
         kind_ff <= kind_in;
         pb_ff <= pb_in;
         slot_ff <= slot_in;
         sid_ff <= sid_in;
         ct_ff <= ct_in;
         cf_ff <= cf_in;
         cv_ff <= cv_in;
         ec_ff <= ec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff <= RESET_WINDOW;
         dl_ff <= RESET_DISCARD;
         hcnt_ff <= '0;
         fa_ff <= 1'b0;
         left_ff <= '0;
         fstream_ff <= '0;
         fflags_ff <= '0;
         drop_ff <= 1'b0;
         dt_ff <= '0;
         nlid_ff <= 32'd1;
         phid_ff <= '0;
         gone_ff <= 1'b0;
         sticky_ff <= E_NONE;
         ov_ff <= 1'b0;
         for (int i = 0; i < STREAM_SLOTS; i++) begin
            ids_ff[i] <= '0;
            marks_ff[i] <= '0;
         end
      end else begin
         if (cfg_write) begin
            if (cfg_sel == REG_INITIAL_WINDOW) iw_ff <= cfg_wdata;
            else dl_ff <= cfg_wdata;
         end
         if (cmd.exec) begin
            hcnt_ff <= hcnt_in;
            fa_ff <= fa_in;
            left_ff <= left_in;
            fstream_ff <= fstream_in;
            fflags_ff <= fflags_in;
            drop_ff <= drop_in;
            dt_ff <= dt_in;
            nlid_ff <= nlid_in;
            phid_ff <= phid_in;
            gone_ff <= gone_in;
            sticky_ff <= sticky_in;
            if (we_ids) ids_ff[widx] <= w_ids;
            if (we_marks) marks_ff[widx] <= w_marks;
            ov_ff <= 1'b1;
         end else if (!rsp_stall) begin
            ov_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_out_kind = kind_ff;
   assign rsp_payload_byte = pb_ff;
   assign rsp_stream_slot = slot_ff;
   assign rsp_stream_id = sid_ff;
   assign rsp_ctrl_type = ct_ff;
   assign rsp_ctrl_flags = cf_ff;
   assign rsp_ctrl_value = cv_ff;
   assign rsp_error_code = ec_ff;

endmodule

// ===== hdl/yamux_receive_deframer_top.sv =====
// Channel  | Handshake           | Words
// req      | req_valid/req_stall | req_type, req_data_byte, req_credit_slot, req_credit_amount
// rsp      | rsp_valid/rsp_stall | rsp_out_kind ... rsp_error_code
// csr      | psel/penable/pready | paddr, pwdata, prdata (two 32-bit registers)
// Each word passes through a stream table lookup state (parallel id compare over
// the slots) and then an execute state that updates state and loads the result register.
// A new word is taken when idle, or in the execute state when the result register is free.
// A stalled result holds the execute cycle; reset is synchronous and needs no clearing pass.
module yamux_receive_deframer_top
   import yrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_data_byte,
   input  logic [2:0]  req_credit_slot,
   input  logic [31:0] req_credit_amount,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_out_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [2:0]  rsp_stream_slot,
   output logic [31:0] rsp_stream_id,
   output logic [1:0]  rsp_ctrl_type,
   output logic [3:0]  rsp_ctrl_flags,
   output logic [31:0] rsp_ctrl_value,
   output logic [2:0]  rsp_error_code,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cmd_type cmd;
   status_type status;
   logic cfg_write;

   assign pready = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   yrd_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status(status),
      .cmd(cmd)
   );

   yrd_datapath u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_type(req_type),
      .req_data_byte(req_data_byte),
      .req_credit_slot(req_credit_slot),
      .req_credit_amount(req_credit_amount),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_kind(rsp_out_kind),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_stream_slot(rsp_stream_slot),
      .rsp_stream_id(rsp_stream_id),
      .rsp_ctrl_type(rsp_ctrl_type),
      .rsp_ctrl_flags(rsp_ctrl_flags),
      .rsp_ctrl_value(rsp_ctrl_value),
      .rsp_error_code(rsp_error_code),
      .cfg_write(cfg_write),
      .cfg_sel(paddr[2]),
      .cfg_wdata(pwdata),
      .cfg_rdata(prdata)
   );

endmodule

// ===== hdl/yrd_checker.sv =====
module yrd_checker
   import yrd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_out_kind,
   input logic [2:0] rsp_error_code
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result word dropped");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("word taken during lookup");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_kind <= K_ERROR) else $error("bad result kind");

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == K_ERROR |-> rsp_error_code != E_NONE)
      else $error("error result without code");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result valid after reset");

endmodule

bind yamux_receive_deframer_top yrd_checker u_yrd_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_out_kind(rsp_out_kind),
   .rsp_error_code(rsp_error_code)
);

// ===== bench/yamux_receive_deframer_top_tb.sv =====
module yamux_receive_deframer_top_tb;
   import yrd_pkg::*;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  pbyte;
      logic [2:0]  slot;
      logic [31:0] id;
      logic [1:0]  ctype;
      logic [3:0]  cflags;
      logic [31:0] cval;
      logic [2:0]  err;
   } frame_result_type;

   typedef struct {
      logic [1:0]       t;
      logic [7:0]       b;
      logic [2:0]       sl;
      logic [31:0]      amt;
      bit               typed;
      frame_result_type want;
   } stim_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_type = 0;
   logic [7:0]  req_data_byte = 0;
   logic [2:0]  req_credit_slot = 0;
   logic [31:0] req_credit_amount = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [2:0]  rsp_out_kind;
   logic [7:0]  rsp_payload_byte;
   logic [2:0]  rsp_stream_slot;
   logic [31:0] rsp_stream_id;
   logic [1:0]  rsp_ctrl_type;
   logic [3:0]  rsp_ctrl_flags;
   logic [31:0] rsp_ctrl_value;
   logic [2:0]  rsp_error_code;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [2:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;

   yamux_receive_deframer_top u_dut (.*);

   always #5 clock = ~clock;

   // Shadow of the deframer state.
   logic [31:0] win_cfg, drop_cfg;
   logic [7:0]  hdr [HDR_LEN];
   int          hdr_cnt;
   bit          in_frame, cur_drop, gone;
   logic [31:0] bytes_left, cur_stream, drop_total, next_id, peer_top;
   logic [3:0]  cur_flags;
   logic [2:0]  stuck;
   logic [31:0] ids [STREAM_SLOTS];
   logic [2:0]  marks [STREAM_SLOTS];
   logic [31:0] rx_cred [STREAM_SLOTS];
   logic [31:0] tx_cred [STREAM_SLOTS];

   frame_result_type expected_q[$];
   int          fail_cnt = 0;
   int          idle_cycles = 0;
   int          burst_left = 0;
   int          stall_mode = 0;
   int          cyc = 0;
   int          words_sent = 0;

   function automatic frame_result_type res(logic [2:0] kind, logic [7:0] pb, logic [2:0] sl,
      logic [31:0] id, logic [1:0] ct, logic [3:0] cf, logic [31:0] cv, logic [2:0] er);
      frame_result_type r;
      r.kind = kind; r.pbyte = pb; r.slot = sl; r.id = id;
      r.ctype = ct; r.cflags = cf; r.cval = cv; r.err = er;
      return r;
   endfunction

   function automatic frame_result_type fault(logic [2:0] code);
      stuck = code;
      return res(K_ERROR, 0, 0, 0, 0, 0, 0, code);
   endfunction

   function automatic int lookup(logic [31:0] id);
      if (id == 0) return -1;
      for (int i = 0; i < STREAM_SLOTS; i++)
         if (ids[i] == id) return i;
      return -1;
   endfunction

   function automatic logic [31:0] room();
      return drop_total > drop_cfg ? 32'd0 : drop_cfg - drop_total;
   endfunction

   function automatic void close_frame();
      int s = lookup(cur_stream);
      if (s >= 0 && !marks[s][M_RESET] && cur_flags[2]) marks[s][M_RFIN] = 1'b1;
      in_frame = 0;
      hdr_cnt = 0;
   endfunction

   function automatic frame_result_type parse_header();
      logic [7:0]  ty = hdr[1];
      logic [15:0] fl = {hdr[2], hdr[3]};
      logic [31:0] id = {hdr[4], hdr[5], hdr[6], hdr[7]};
      logic [31:0] val = {hdr[8], hdr[9], hdr[10], hdr[11]};
      bit          rst_back = 0;
      bit          disc;
      int          s;
      logic [2:0]  mk;
      if (hdr[0] != 0 || ty > 3 || fl[15:4] != 0) return fault(E_PROTO);
      if (ty == T_PING) begin
         if (id != 0 || fl != 16'(F_SYN)) return fault(E_PROTO);
         hdr_cnt = 0;
         return res(K_CTRL, 0, 0, 0, T_PING, F_ACK, val, E_NONE);
      end
      if (ty == T_GOAWAY) begin
         if (id != 0 || fl != 0 || val > 2) return fault(E_PROTO);
         if (val != 0) return fault(E_CLOSED);
         gone = 1;
         hdr_cnt = 0;
         return res(K_NONE, 0, 0, 0, 0, 0, 0, E_NONE);
      end
      if (id == 0 || fl[1:0] == 2'b11 || fl[3:2] == 2'b11) return fault(E_PROTO);
      s = lookup(id);
      if (fl[0]) begin
         if (id[0] || id <= peer_top || fl[3]) return fault(E_PROTO);
         rst_back = 1;
      end else if (id[0] ? (next_id != 0 && id >= next_id) : id > peer_top) begin
         return fault(E_PROTO);
      end
      if (s >= 0 && !marks[s][M_RESET]) begin
         mk = marks[s];
         if (fl[1] && mk[M_ACKED]) return fault(E_PROTO);
         if (!mk[M_ACKED] && !fl[1] && !fl[3]) return fault(E_PROTO);
         if (mk[M_RFIN] && !fl[3] && (ty == T_DATA || fl[2])) return fault(E_PROTO);
         if (ty == T_DATA && val > rx_cred[s]) return fault(E_PROTO);
         if (ty == T_WINDOW && val > ~tx_cred[s]) return fault(E_PROTO);
         if (fl[1]) mk[M_ACKED] = 1'b1;
         if (ty == T_DATA) rx_cred[s] -= val;
         else tx_cred[s] += val;
         if (fl[3]) mk[M_RESET] = 1'b1;
         marks[s] = mk;
      end
      disc = (s < 0) ? 1'b1 : marks[s][M_RESET];
      if (ty == T_DATA && disc && (val > win_cfg || val > room())) return fault(E_PROTO);
      if (rst_back) peer_top = id;
      cur_stream = id;
      cur_flags = fl[3:0];
      cur_drop = disc;
      bytes_left = (ty == T_DATA) ? val : 32'd0;
      in_frame = 1;
      hdr_cnt = 0;
      if (bytes_left == 0) close_frame();
      if (rst_back) return res(K_CTRL, 0, 0, id, T_WINDOW, F_RST, 0, E_NONE);
      return res(K_NONE, 0, 0, 0, 0, 0, 0, E_NONE);
   endfunction

   function automatic frame_result_type take_byte(logic [7:0] b);
      frame_result_type r;
      int s;
      if (!in_frame) begin
         if (hdr_cnt >= HDR_LEN) hdr_cnt = 0;
         hdr[hdr_cnt] = b;
         hdr_cnt++;
         if (hdr_cnt < HDR_LEN) return res(K_NONE, 0, 0, 0, 0, 0, 0, E_NONE);
         return parse_header();
      end
      if (cur_drop) begin
         if (room() < 1) return fault(E_PROTO);
         drop_total++;
         r = res(K_NONE, 0, 0, 0, 0, 0, 0, E_NONE);
      end else begin
         s = lookup(cur_stream);
         if (s < 0) return fault(E_STATE);
         r = res(K_PAYLOAD, b, s[2:0], cur_stream, 0, 0, 0, E_NONE);
      end
      bytes_left--;
      if (bytes_left == 0) close_frame();
      return r;
   endfunction

   function automatic frame_result_type open_stream();
      int s = -1;
      logic [31:0] id;
      if (gone) return res(K_ERROR, 0, 0, 0, 0, 0, 0, E_CLOSED);
      for (int i = STREAM_SLOTS - 1; i >= 0; i--)
         if (ids[i] == 0) s = i;
      if (next_id == 0 || s < 0) return res(K_ERROR, 0, 0, 0, 0, 0, 0, E_CAP);
      id = next_id;
      ids[s] = id;
      marks[s] = 0;
      rx_cred[s] = win_cfg;
      tx_cred[s] = win_cfg;
      next_id = (id == 32'hFFFF_FFFF) ? 32'd0 : id + 2;
      return res(K_OPENED, 0, s[2:0], id, T_WINDOW, F_SYN, 0, E_NONE);
   endfunction

   function automatic frame_result_type grant_credit(logic [2:0] sl, logic [31:0] amt);
      if (ids[sl] == 0 || marks[sl][M_RESET] || marks[sl][M_RFIN] || amt == 0)
         return res(K_NONE, 0, 0, 0, 0, 0, 0, E_NONE);
      if (rx_cred[sl] > win_cfg || amt > win_cfg - rx_cred[sl]) return fault(E_PROTO);
      rx_cred[sl] += amt;
      return res(K_CTRL, 0, 0, ids[sl], T_WINDOW, 0, amt, E_NONE);
   endfunction

   function automatic frame_result_type predict_word(logic [1:0] t, logic [7:0] b,
      logic [2:0] sl, logic [31:0] amt);
      if (t == REQ_UNKNOWN) return res(K_NONE, 0, 0, 0, 0, 0, 0, E_NONE);
      if (stuck != E_NONE) return res(K_ERROR, 0, 0, 0, 0, 0, 0, stuck);
      case (t)
         REQ_BYTE: return take_byte(b);
         REQ_OPEN: return open_stream();
         default:  return grant_credit(sl, amt);
      endcase
   endfunction

   task automatic send_word(logic [1:0] t, logic [7:0] b, logic [2:0] sl, logic [31:0] amt,
      bit typed = 0, frame_result_type want = '0);
      frame_result_type r;
      r = predict_word(t, b, sl, amt);
      expected_q.push_back(typed ? want : r);
      words_sent++;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_type <= t;
      req_data_byte <= b;
      req_credit_slot <= sl;
      req_credit_amount <= amt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_header(logic [7:0] ver, logic [7:0] ty, logic [15:0] fl,
      logic [31:0] id, logic [31:0] val);
      logic [95:0] h = {ver, ty, fl, id, val};
      for (int i = 0; i < HDR_LEN; i++) send_word(REQ_BYTE, h[95 - 8 * i -: 8], 0, 0);
   endtask

   task automatic drain_frame();
      while (in_frame && stuck == E_NONE) send_word(REQ_BYTE, 8'($urandom), 0, 0);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(logic [31:0] w, logic [31:0] d);
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_write({REG_INITIAL_WINDOW, 2'b00}, w);
      csr_write({REG_DISCARD_LIMIT, 2'b00}, d);
      win_cfg = w;
      drop_cfg = d;
   endtask

   task automatic random_frame(bit late);
      int s = -1, st, pick;
      logic [3:0] fl;
      logic [7:0] ty;
      logic [31:0] v, lim;
      pick = $urandom_range(0, 99);
      st = $urandom_range(0, STREAM_SLOTS - 1);
      if (pick < 10) begin
         send_header(0, T_PING, F_SYN, 0, $urandom);
         return;
      end
      if (late && pick < 11) begin
         send_header(0, T_GOAWAY, 0, 0, 0);
         return;
      end
      if (pick < 25) begin
         for (int i = 0; i < STREAM_SLOTS; i++)
            if (ids[(st + i) % STREAM_SLOTS] != 0 && marks[(st + i) % STREAM_SLOTS][M_RESET])
               s = (st + i) % STREAM_SLOTS;
         if (s >= 0) v = ids[s];
         else if (peer_top != 0) v = peer_top;
         else begin
            send_header(0, T_WINDOW, F_SYN, peer_top + 2, 0);
            return;
         end
         lim = room() < win_cfg ? room() : win_cfg;
         fl = 4'($urandom_range(0, 4));
         if (32'(fl) > lim) fl = lim[3:0];
         send_header(0, T_DATA, 0, v, 32'(fl));
         drain_frame();
         return;
      end
      if (pick < 30) begin
         send_header(0, T_WINDOW, F_SYN, peer_top + 2 * $urandom_range(1, 3), 0);
         return;
      end
      for (int i = 0; i < STREAM_SLOTS; i++)
         if (ids[(st + i) % STREAM_SLOTS] != 0 && !marks[(st + i) % STREAM_SLOTS][M_RESET])
            s = (st + i) % STREAM_SLOTS;
      if (s < 0) begin
         send_word(REQ_OPEN, 8'($urandom), 3'($urandom), $urandom);
         return;
      end
      fl = marks[s][M_ACKED] ? 4'd0 : F_ACK;
      ty = (marks[s][M_RFIN] || $urandom_range(0, 1)) ? T_WINDOW : T_DATA;
      pick = $urandom_range(0, 59);
      if (pick == 0) fl |= F_RST;
      else if (pick < 6 && !marks[s][M_RFIN]) fl |= F_FIN;
      if (ty == T_DATA) begin
         v = $urandom_range(0, 6);
         if (v > rx_cred[s]) v = rx_cred[s];
      end else begin
         v = $urandom;
         if (v > ~tx_cred[s]) v = ~tx_cred[s];
      end
      send_header(0, ty, 16'(fl), ids[s], v);
      drain_frame();
   endtask

   task automatic random_phase(int n, bit late);
      int start = words_sent;
      int pick, sl;
      logic [31:0] amt;
      while (words_sent - start < n) begin
         pick = $urandom_range(0, 99);
         sl = $urandom_range(0, STREAM_SLOTS - 1);
         if (pick < 8) send_word(REQ_OPEN, 8'($urandom), 3'($urandom), $urandom);
         else if (pick < 12) send_word(REQ_UNKNOWN, 8'($urandom), 3'($urandom), $urandom);
         else if (pick < 28) begin
            amt = 0;
            if (ids[sl] != 0 && rx_cred[sl] < win_cfg && $urandom_range(0, 5) != 0) begin
               amt = $urandom;
               if (amt > win_cfg - rx_cred[sl] || amt == 0) amt = win_cfg - rx_cred[sl];
            end
            send_word(REQ_CREDIT, 8'($urandom), sl[2:0], amt);
         end else random_frame(late);
      end
      drain_frame();
   endtask

   function automatic stim_row_type row(logic [1:0] t, logic [7:0] b, logic [2:0] sl,
      logic [31:0] amt, bit typed = 0, frame_result_type want = '0);
      stim_row_type r;
      r.t = t; r.b = b; r.sl = sl; r.amt = amt; r.typed = typed; r.want = want;
      return r;
   endfunction

   always @(posedge clock) begin
      frame_result_type got, want;
      cyc <= cyc + 1;
      if (cyc % 200 == 0) stall_mode <= $urandom_range(0, 2);
      if (rsp_valid && !rsp_stall) begin
         got = res(rsp_out_kind, rsp_payload_byte, rsp_stream_slot, rsp_stream_id,
                   rsp_ctrl_type, rsp_ctrl_flags, rsp_ctrl_value, rsp_error_code);
         if (expected_q.size() == 0) begin
            fail_cnt++;
            if (fail_cnt < 30) $display("%0t unexpected word: actual %h", $time, got);
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               fail_cnt++;
               if (fail_cnt < 30)
                  $display("%0t mismatch: expected %h actual %h", $time, want, got);
            end
         end
      end
      rsp_stall <= (stall_mode == 1) ? ($urandom_range(0, 2) == 0) :
                   (stall_mode == 2) ? ($urandom_range(0, 5) != 0) : 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 5000) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      stim_row_type rows[$];
      logic [7:0] ping [HDR_LEN] = '{0, 2, 0, 1, 0, 0, 0, 0, 8'hDE, 8'hAD, 8'hBE, 8'hEF};
      logic [7:0] peer [HDR_LEN] = '{0, 1, 0, 1, 0, 0, 0, 2, 0, 0, 0, 0};
      logic [7:0] bad [HDR_LEN] = '{1, 0, 0, 2, 0, 0, 0, 1, 0, 0, 0, 0};
      win_cfg = RESET_WINDOW;
      drop_cfg = RESET_DISCARD;
      hdr_cnt = 0; in_frame = 0; cur_drop = 0; gone = 0;
      bytes_left = 0; cur_stream = 0; cur_flags = 0; drop_total = 0;
      next_id = 1; peer_top = 0; stuck = E_NONE;
      for (int i = 0; i < STREAM_SLOTS; i++) begin
         ids[i] = 0; marks[i] = 0; rx_cred[i] = 0; tx_cred[i] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows.push_back(row(REQ_OPEN, 0, 0, 0, 1, res(K_OPENED, 0, 0, 1, T_WINDOW, F_SYN, 0, 0)));
      rows.push_back(row(REQ_UNKNOWN, 8'hFF, 7, 32'hFFFF_FFFF, 1, '0));
      rows.push_back(row(REQ_CREDIT, 0, 3, 32'hFFFF_FFFF, 1, '0));
      rows.push_back(row(REQ_CREDIT, 0, 0, 0, 1, '0));
      for (int i = 0; i < HDR_LEN - 1; i++) rows.push_back(row(REQ_BYTE, ping[i], 0, 0));
      rows.push_back(row(REQ_BYTE, ping[HDR_LEN - 1], 0, 0, 1,
                         res(K_CTRL, 0, 0, 0, T_PING, F_ACK, 32'hDEADBEEF, 0)));
      for (int i = 0; i < HDR_LEN - 1; i++) rows.push_back(row(REQ_BYTE, peer[i], 0, 0));
      rows.push_back(row(REQ_BYTE, peer[HDR_LEN - 1], 0, 0, 1,
                         res(K_CTRL, 0, 0, 2, T_WINDOW, F_RST, 0, 0)));
      foreach (rows[i]) send_word(rows[i].t, rows[i].b, rows[i].sl, rows[i].amt,
                                  rows[i].typed, rows[i].want);

      set_config(RESET_WINDOW, RESET_DISCARD);
      random_phase(360, 0);
      set_config(32'd1, 32'd0);
      random_phase(360, 0);
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      random_phase(360, 0);
      set_config(32'd1000, 32'd20);
      random_phase(360, 0);
      set_config($urandom_range(1, 32'h7FFF_FFFF), $urandom);
      random_phase(360, 1);

      drain_frame();
      for (int i = 0; i < HDR_LEN - 1; i++) send_word(REQ_BYTE, bad[i], 0, 0);
      send_word(REQ_BYTE, bad[HDR_LEN - 1], 0, 0, stuck == E_NONE,
                res(K_ERROR, 0, 0, 0, 0, 0, 0, E_PROTO));
      send_word(REQ_OPEN, 0, 0, 0, stuck == E_PROTO, res(K_ERROR, 0, 0, 0, 0, 0, 0, E_PROTO));
      for (int i = 0; i < 20; i++)
         send_word(2'($urandom), 8'($urandom), 3'($urandom), $urandom);

      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_cnt == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
